>>> rtl/qrci_pkg.sv
// Shared constants, register codes and controller/datapath structs for the codeword interleaver.
`timescale 1ns / 1ps
package qrci_pkg;

	localparam int STORE_DEPTH = 4096;
	localparam int MAX_BLOCKS  = 128;

	localparam int ADDR_W   = $clog2(STORE_DEPTH);
	localparam int CNT_W    = $clog2(STORE_DEPTH + 1);
	localparam int CW_W     = 8;
	localparam int BLK_W    = 7;
	localparam int LEN_W    = 8;
	localparam int EC_W     = 6;
	localparam int NB_W     = 8;
	localparam int PROD_W   = 15;
	localparam int TOT_W    = 17;
	localparam int IDX_W    = 3;
	localparam int SETTLE_W = 2;

	localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;
	localparam logic [NB_W:0]       MAX_BLOCKS_V  = (NB_W + 1)'(MAX_BLOCKS);
	localparam logic [TOT_W-1:0]    STORE_DEPTH_V = TOT_W'(STORE_DEPTH);

	// register indexes
	localparam logic [IDX_W-1:0] REG_G1_BLOCKS   = 3'd0;
	localparam logic [IDX_W-1:0] REG_G1_LEN      = 3'd1;
	localparam logic [IDX_W-1:0] REG_G2_BLOCKS   = 3'd2;
	localparam logic [IDX_W-1:0] REG_G2_LEN      = 3'd3;
	localparam logic [IDX_W-1:0] REG_EC_PER_BLK  = 3'd4;

	// register reset values
	localparam logic [BLK_W-1:0] G1_BLOCKS_RST = 7'd1;
	localparam logic [LEN_W-1:0] G1_LEN_RST    = 8'd19;
	localparam logic [BLK_W-1:0] G2_BLOCKS_RST = 7'd0;
	localparam logic [LEN_W-1:0] G2_LEN_RST    = 8'd0;
	localparam logic [EC_W-1:0]  EC_PER_BLK_RST = 6'd7;

	// transaction modes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_FETCH = 1'b1;

	typedef struct packed {
		logic load_wr;
		logic fault_out;
		logic seek_step;
		logic issue;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic usable;
		logic load_full;
		logic load_ready;
		logic at_valid;
		logic out_busy;
		logic settled;
	} dp_sts_t;

endpackage

>>> rtl/qrci_if.sv
// Valid/ready channel interfaces for the input and result transactions.
`timescale 1ns / 1ps
interface qrci_in_if;
	import qrci_pkg::*;
	logic            valid;
	logic            ready;
	logic            mode;
	logic [CW_W-1:0] codeword;

	modport source (output valid, output mode, output codeword, input ready);
	modport sink (input valid, input mode, input codeword, output ready);
endinterface

interface qrci_out_if;
	import qrci_pkg::*;
	logic            valid;
	logic            ready;
	logic [CW_W-1:0] out_codeword;
	logic            is_ec;
	logic            last;
	logic            fault;

	modport source (output valid, output out_codeword, output is_ec, output last,
		output fault, input ready);
	modport sink (input valid, input out_codeword, input is_ec, input last,
		input fault, output ready);
endinterface

>>> rtl/qrci_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module qrci_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> rtl/qrci_dp.sv
// Datapath: configuration registers, derived sizes, load/fetch counters, store and result register.
`timescale 1ns / 1ps
module qrci_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [qrci_pkg::IDX_W-1:0]   cfg_index,
	input  logic [qrci_pkg::CW_W-1:0]    cfg_wdata,
	input  logic [qrci_pkg::CW_W-1:0]    in_codeword,
	input  logic                         out_ready,
	input  qrci_pkg::dp_cmd_t            cmd,
	output qrci_pkg::dp_sts_t            sts,
	output logic                         out_valid,
	output logic [qrci_pkg::CW_W-1:0]    out_codeword,
	output logic                         is_ec,
	output logic                         last,
	output logic                         fault
);
	import qrci_pkg::*;

	logic [BLK_W-1:0]    g1_blocks_q;
	logic [LEN_W-1:0]    g1_len_q;
	logic [BLK_W-1:0]    g2_blocks_q;
	logic [LEN_W-1:0]    g2_len_q;
	logic [EC_W-1:0]     ec_len_q;
	logic [SETTLE_W-1:0] settle_q;
	logic                cfg_hit;

	logic [PROD_W-1:0]   prod1_s1;
	logic [PROD_W-1:0]   prod2_s1;
	logic [PROD_W-1:0]   prod3_s1;
	logic [NB_W-1:0]     nb_s1;
	logic [LEN_W-1:0]    maxlen_s1;
	logic [NB_W-1:0]     nb_sum;
	logic [TOT_W-1:0]    data_total_s2;
	logic [TOT_W-1:0]    total_s2;
	logic                usable_s3;

	logic [CNT_W-1:0]    load_cnt_q;
	logic [CNT_W-1:0]    emit_cnt_q;
	logic [LEN_W-1:0]    round_q;
	logic [NB_W-1:0]     blk_q;
	logic                ec_phase_q;
	logic [TOT_W-1:0]    addr_q;

	logic [TOT_W-1:0]    load_ext;
	logic [TOT_W-1:0]    emit_ext;
	logic                in_g1;
	logic [LEN_W-1:0]    blen;
	logic                wrap;
	logic                last_hit;
	logic [LEN_W-1:0]    round_inc;
	logic [TOT_W-1:0]    phase_base;
	logic [TOT_W-1:0]    addr_step;

	logic [CW_W-1:0]     rd_data;
	logic                pend_is_ec_q;
	logic                pend_last_q;
	logic                out_valid_q;
	logic [CW_W-1:0]     out_codeword_q;
	logic                is_ec_q;
	logic                last_q;
	logic                fault_q;

	assign cfg_hit = cfg_we && (cfg_index <= REG_EC_PER_BLK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g1_blocks_q <= G1_BLOCKS_RST;
			g1_len_q    <= G1_LEN_RST;
			g2_blocks_q <= G2_BLOCKS_RST;
			g2_len_q    <= G2_LEN_RST;
			ec_len_q    <= EC_PER_BLK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_G1_BLOCKS:  g1_blocks_q <= cfg_wdata[BLK_W-1:0];
				REG_G1_LEN:     g1_len_q    <= cfg_wdata[LEN_W-1:0];
				REG_G2_BLOCKS:  g2_blocks_q <= cfg_wdata[BLK_W-1:0];
				REG_G2_LEN:     g2_len_q    <= cfg_wdata[LEN_W-1:0];
				REG_EC_PER_BLK: ec_len_q    <= cfg_wdata[EC_W-1:0];
				default: ;
			endcase
		end
	end

	// hold off transactions until the size pipeline reflects the registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_CYCLES;
		end else if (cfg_we) begin
			settle_q <= SETTLE_CYCLES;
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	assign nb_sum = NB_W'(g1_blocks_q) + NB_W'(g2_blocks_q);

	always_ff @(posedge clk) begin
		prod1_s1  <= PROD_W'(g1_blocks_q) * PROD_W'(g1_len_q);
		prod2_s1  <= PROD_W'(g2_blocks_q) * PROD_W'(g2_len_q);
		prod3_s1  <= PROD_W'(nb_sum) * PROD_W'(ec_len_q);
		nb_s1     <= nb_sum;
		maxlen_s1 <= (g1_len_q > g2_len_q) ? g1_len_q : g2_len_q;

		data_total_s2 <= TOT_W'(prod1_s1) + TOT_W'(prod2_s1);
		total_s2      <= TOT_W'(prod1_s1) + TOT_W'(prod2_s1) + TOT_W'(prod3_s1);

		usable_s3 <= (nb_s1 != '0) && ({1'b0, nb_s1} <= MAX_BLOCKS_V) &&
			(total_s2 != '0) && (total_s2 <= STORE_DEPTH_V);
	end

	assign load_ext   = TOT_W'(load_cnt_q);
	assign emit_ext   = TOT_W'(emit_cnt_q);
	assign in_g1      = blk_q < NB_W'(g1_blocks_q);
	assign blen       = in_g1 ? g1_len_q : g2_len_q;
	assign wrap       = blk_q >= nb_s1;
	assign last_hit   = (emit_ext + TOT_W'(1)) >= total_s2;
	assign round_inc  = round_q + 1'b1;
	assign phase_base = ec_phase_q ? data_total_s2 : '0;
	assign addr_step  = ec_phase_q ? TOT_W'(ec_len_q) : TOT_W'(blen);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			emit_cnt_q <= '0;
			round_q    <= '0;
			blk_q      <= '0;
			ec_phase_q <= 1'b0;
			addr_q     <= '0;
		end else if (cfg_hit || (cmd.issue && last_hit)) begin
			// message done or geometry changed: back to empty
			load_cnt_q <= '0;
			emit_cnt_q <= '0;
			round_q    <= '0;
			blk_q      <= '0;
			ec_phase_q <= 1'b0;
			addr_q     <= '0;
		end else if (cmd.load_wr) begin
			load_cnt_q <= load_cnt_q + 1'b1;
		end else if (cmd.seek_step) begin
			if (wrap) begin
				blk_q   <= '0;
				round_q <= round_inc;
				addr_q  <= phase_base + TOT_W'(round_inc);
			end else if (!ec_phase_q && (round_q >= maxlen_s1)) begin
				ec_phase_q <= 1'b1;
				round_q    <= '0;
				blk_q      <= '0;
				addr_q     <= data_total_s2;
			end else if (in_g1) begin
				// every group one block is used up this round: jump to group two
				blk_q  <= NB_W'(g1_blocks_q);
				addr_q <= TOT_W'(prod1_s1) + TOT_W'(round_q);
			end else begin
				blk_q <= nb_s1;
			end
		end else if (cmd.issue) begin
			blk_q      <= blk_q + 1'b1;
			emit_cnt_q <= emit_cnt_q + 1'b1;
			addr_q     <= addr_q + addr_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			pend_is_ec_q <= ec_phase_q;
			pend_last_q  <= last_hit;
		end
	end

	qrci_ram #(
		.WIDTH(CW_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.load_wr),
		.waddr(load_cnt_q[ADDR_W-1:0]),
		.wdata(in_codeword),
		.re   (cmd.issue),
		.raddr(addr_q[ADDR_W-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fault_out || cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fault_out) begin
			out_codeword_q <= '0;
			is_ec_q        <= 1'b0;
			last_q         <= 1'b0;
			fault_q        <= 1'b1;
		end else if (cmd.emit) begin
			out_codeword_q <= rd_data;
			is_ec_q        <= pend_is_ec_q;
			last_q         <= pend_last_q;
			fault_q        <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_codeword = out_codeword_q;
	assign is_ec        = is_ec_q;
	assign last         = last_q;
	assign fault        = fault_q;

	assign sts.usable     = usable_s3;
	assign sts.load_full  = load_ext >= total_s2;
	assign sts.load_ready = (load_ext == total_s2) && (emit_ext < total_s2);
	assign sts.at_valid   = !wrap && (ec_phase_q || (round_q < blen));
	assign sts.out_busy   = out_valid_q && !out_ready;
	assign sts.settled    = settle_q == '0;
endmodule

>>> rtl/qrci_ctrl.sv
// Controller: accepts transactions and sequences the seek, store read and result hand-off.
`timescale 1ns / 1ps
module qrci_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_mode,
	output logic              in_ready,
	input  qrci_pkg::dp_sts_t sts,
	output qrci_pkg::dp_cmd_t cmd
);
	import qrci_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SEEK = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = sts.settled && !sts.out_busy;
				if (in_valid && in_ready) begin
					if (!sts.usable) begin
						cmd.fault_out = 1'b1;
					end else if (in_mode == MODE_LOAD) begin
						if (sts.load_full) begin
							cmd.fault_out = 1'b1;
						end else begin
							cmd.load_wr = 1'b1;
						end
					end else if (!sts.load_ready) begin
						cmd.fault_out = 1'b1;
					end else begin
						state_d = ST_SEEK;
					end
				end
			end
			ST_SEEK: begin
				// advance one step per cycle until the pointer lands on a real codeword
				if (sts.at_valid) begin
					cmd.issue = 1'b1;
					state_d   = ST_EMIT;
				end else begin
					cmd.seek_step = 1'b1;
				end
			end
			ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

>>> rtl/qr_codeword_interleaver.sv
// Top level of the QR codeword interleaver.
//
// Usage: configure the block geometry through the write port (cfg_we, cfg_index,
// cfg_wdata) while idle; any write to a known register empties the message. Then send
// load transactions (mode 0) carrying the message bytes in block order, data first and
// error correction after, and finally fetch transactions (mode 1), each returning the
// next codeword of the interleaved order on out_ch. Loads return nothing; a refused load
// or fetch returns one result with fault set and all other fields zero.
// A fetch walks the round/block pointer one step per cycle after acceptance (row wrap,
// group skip, phase change; at most three steps), then issues the registered store
// read, whose data goes into the result register. A group with no blocks but the
// longest block length leaves empty rounds, and each of them adds a group skip and a
// row wrap to the walk. The controller stays idle after a load, so the next
// transaction can follow it directly; after a fetch it is taken in the cycle after the
// result register is loaded, if the receiver takes the result in that cycle. A refused
// transaction returns its result in the cycle after acceptance. After reset and after
// each register write the input is held off while the message size pipeline
// (multipliers, sums, range check) settles. A stalled receiver holds the result register
// and the input with it; a transaction is taken in the cycle the receiver takes the result.
`timescale 1ns / 1ps
module qr_codeword_interleaver (
	input  logic                       clk,
	input  logic                       arst_n,
	qrci_in_if.sink                    in_ch,
	qrci_out_if.source                 out_ch,
	input  logic                       cfg_we,
	input  logic [qrci_pkg::IDX_W-1:0] cfg_index,
	input  logic [qrci_pkg::CW_W-1:0]  cfg_wdata
);
	import qrci_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    in_ready;

	qrci_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_mode (in_ch.mode),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	qrci_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_codeword (in_ch.codeword),
		.out_ready   (out_ch.ready),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_ch.valid),
		.out_codeword(out_ch.out_codeword),
		.is_ec       (out_ch.is_ec),
		.last        (out_ch.last),
		.fault       (out_ch.fault)
	);

	assign in_ch.ready = in_ready;

`ifndef SYNTHESIS
	a_fault_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.fault |->
			(out_ch.out_codeword == '0) && !out_ch.is_ec && !out_ch.last)
		else $error("fault result carries nonzero fields");

	a_load_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_wr |-> sts.usable && !sts.load_full)
		else $error("store write beyond message size");

	a_fetch_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.seek_step || cmd.issue) |-> sts.load_ready)
		else $error("fetch sequencing without a complete load");

	a_settle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!sts.settled |-> !in_ch.ready)
		else $error("input taken while sizes settle");
`endif
endmodule
